FILE: hw/rtl/power_iteration_dominant_eigen_macros.svh
// assertion macros for the power iteration block
`ifndef POWER_ITERATION_DOMINANT_EIGEN_MACROS_SVH
`define POWER_ITERATION_DOMINANT_EIGEN_MACROS_SVH

// implication checked on every clock edge outside reset
`define PIDE_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PIDE_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

FILE: hw/rtl/pide_pkg.sv
// shared types and constants for the power iteration block
package pide_pkg;

    localparam int MAX_ORDER = 8;
    localparam int VAL_W    = 32;
    localparam int Z_W      = 37;
    localparam int ITER_W   = 16;
    localparam int TOL_W    = 31;
    localparam int ORDER_W  = 4;
    localparam int CFG_W    = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_MATRIX = 2'd0;
    localparam logic [1:0] CMD_VECTOR = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO      = 2'd2;

    // divider request and response between sequencer and divide unit
    typedef struct packed {
        logic                 start;
        logic [Z_W-1:0]       num_mag;
        logic [Z_W-1:0]       den_mag;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic                 busy;
        logic [VAL_W-1:0]     quot;
    } div_rsp_t;

endpackage

FILE: hw/rtl/pide_divider.sv
// restoring divider: num * 2^FRAC_BITS / den, one quotient bit per cycle, magnitudes
module pide_divider #(
    parameter int FRAC_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pide_pkg::div_req_t  req,
    output pide_pkg::div_rsp_t  rsp
);
    localparam int ZW    = pide_pkg::Z_W;
    localparam int STEPS = ZW + FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [ZW:0]         rem_reg, rem_next;
    logic [ZW-1:0]       den_reg;
    logic [ZW-1:0]       num_reg;
    logic [pide_pkg::VAL_W-1:0] q_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg, done_reg;
    logic [ZW:0]         trial;
    logic [ZW:0]         diff;

    // shift in one numerator bit (num is at most den, so quotient fits FRAC_BITS+1 bits)
    always_comb begin
        trial    = {rem_reg[ZW-1:0], num_reg[ZW-1]};
        diff     = trial - {1'b0, den_reg};
        rem_next = diff[ZW] ? trial : diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
                rem_reg  <= '0;
                num_reg  <= req.num_mag;
                den_reg  <= req.den_mag;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[ZW-2:0], 1'b0};
                q_reg   <= {q_reg[pide_pkg::VAL_W-2:0], ~diff[ZW]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quot = q_reg;
endmodule

FILE: hw/rtl/power_iteration_dominant_eigen.sv
// Power iteration engine, dominant eigenvalue, top level.
// Input stream s_axis: tdata holds {value, col, row} from bit 0 (row [2:0],
// col [5:3], value [37:6]) padded to 40 bits; tuser holds cmd.
// Matrix and guess words are loaded while idle. A start word runs passes of
// matrix read, then multiply-accumulate, on one shared 32x32 multiplier,
// a max-magnitude scan, a check, then n serial divides on one shared
// divider and a second check; s_axis_tready is low for the whole run.
// Output stream m_axis: n words, tdata {element, eigenvalue, iterations,
// status} from bit 0 (element [31:0], eigenvalue [68:32], iterations
// [84:69], status [86:85]) padded to 88 bits, tuser holds index, tlast on
// the final element. A stalled receiver holds the current word; the next
// start is not taken until all words are taken.
// Reset (synchronous, aresetn low) returns to idle with order 3,
// tolerance 839 and limit 1000; matrix and vector contents are undefined
// until written. Config writes belong only in idle, between runs.
module power_iteration_dominant_eigen #(
    parameter int FRAC_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // row, col, value
    input  logic [1:0]   s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,   // element, eigenvalue, iterations, status
    output logic [2:0]   m_axis_tuser,   // index
    output logic         m_axis_tlast
);
`include "power_iteration_dominant_eigen_macros.svh"

    localparam int MAX_ORDER = pide_pkg::MAX_ORDER;
    localparam int IW   = $clog2(MAX_ORDER);
    localparam int NW   = $clog2(MAX_ORDER + 1);
    localparam int ZW   = pide_pkg::Z_W;
    localparam int VW   = pide_pkg::VAL_W;
    localparam int MD   = MAX_ORDER * MAX_ORDER;
    localparam int ACCW = 48;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MAC   = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_DIVGO = 8'b0000_1000,
        S_DIVW  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_DRAIN = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [pide_pkg::ORDER_W-1:0] order_reg;
    logic [pide_pkg::TOL_W-1:0]   tol_reg;
    logic [pide_pkg::ITER_W-1:0]  limit_reg;

    logic signed [VW-1:0] mat_mem [MD];
    logic signed [VW-1:0] vec_reg [MAX_ORDER];
    logic signed [ZW-1:0] z_reg   [MAX_ORDER];
    logic signed [ZW-1:0] lambda_reg;
    logic [VW-1:0]        err_reg;
    logic                 err_big_reg;
    logic [pide_pkg::ITER_W-1:0] iter_reg;
    logic [1:0]           status_reg;

    logic [IW-1:0] i_reg, j_reg;
    logic [NW-1:0] n_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [VW-1:0]   a_rd_reg;
    logic                   mac_ph_reg;

    // unpack input word
    logic [2:0]  in_row, in_col;
    logic [1:0]  in_cmd;
    logic signed [VW-1:0] in_val;
    assign in_row = s_axis_tdata[2:0];
    assign in_col = s_axis_tdata[5:3];
    assign in_val = s_axis_tdata[37:6];
    assign in_cmd = s_axis_tuser;

    logic s_fire, m_fire;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // active order clamp
    logic [NW-1:0] n_act;
    always_comb begin
        if (order_reg == '0) n_act = NW'(1);
        else if (32'(order_reg) > MAX_ORDER) n_act = NW'(MAX_ORDER);
        else n_act = NW'(order_reg);
    end

    // shared multiplier, floor shift, sum
    logic signed [63:0] prod;
    logic signed [ACCW-1:0] prod_sh;
    assign prod    = 64'(a_rd_reg) * 64'(vec_reg[j_reg]);
    assign prod_sh = ACCW'(prod >>> FRAC_BITS);

    // saturate a row sum to 37 bits
    function automatic logic signed [ZW-1:0] sat37(input logic signed [ACCW-1:0] v);
        if (v > ACCW'(64'sd68719476735)) sat37 = {1'b0, {(ZW-1){1'b1}}};
        else if (v < -ACCW'(64'sd68719476736)) sat37 = {1'b1, {(ZW-1){1'b0}}};
        else sat37 = v[ZW-1:0];
    endfunction

    // magnitudes
    function automatic logic [ZW-1:0] mag37(input logic signed [ZW-1:0] v);
        mag37 = v[ZW-1] ? ZW'(-v) : ZW'(v);
    endfunction

    // divider
    pide_pkg::div_req_t dreq;
    pide_pkg::div_rsp_t drsp;
    pide_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp)
    );
    assign dreq.start   = (state_reg == S_DIVGO);
    assign dreq.num_mag = mag37(z_reg[i_reg]);
    assign dreq.den_mag = mag37(lambda_reg);

    logic signed [VW-1:0] y_val;
    logic signed [VW:0]   y_diff;
    logic [VW:0]          y_dmag;
    assign y_val  = (z_reg[i_reg][ZW-1] ^ lambda_reg[ZW-1]) ? -drsp.quot : drsp.quot;
    assign y_diff = {y_val[VW-1], y_val} - {vec_reg[i_reg][VW-1], vec_reg[i_reg]};
    assign y_dmag = y_diff[VW] ? (VW+1)'(-y_diff) : y_diff;

    logic last_i;
    assign last_i = ({1'b0, i_reg} == (NW+1)'(n_reg) - 1'b1);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 4'd3;
            tol_reg   <= 31'd839;
            limit_reg <= 16'd1000;
        end else if (cfg_we) begin
            case (cfg_index)
                pide_pkg::REG_ORDER: order_reg <= cfg_data[pide_pkg::ORDER_W-1:0];
                pide_pkg::REG_TOL:   tol_reg   <= cfg_data;
                pide_pkg::REG_LIMIT: limit_reg <= cfg_data[pide_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // matrix memory: write on load, registered read during mac
    logic [IW-1:0] ld_row, ld_col;
    assign ld_row = in_row[IW-1:0];
    assign ld_col = in_col[IW-1:0];
    logic ld_ok;
    assign ld_ok = (32'(in_row) < MAX_ORDER) && (32'(in_col) < MAX_ORDER);
    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == pide_pkg::CMD_MATRIX && ld_ok)
            mat_mem[{ld_row, ld_col}] <= in_val;
        a_rd_reg <= mat_mem[{i_reg, j_reg}];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            iter_reg   <= '0;
            lambda_reg <= '0;
            err_reg    <= '0;
            status_reg <= pide_pkg::ST_CONVERGED;
            mac_ph_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            n_reg <= NW'(1);
            for (int k = 0; k < MAX_ORDER; k++) z_reg[k] <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        if (in_cmd == pide_pkg::CMD_VECTOR && 32'(in_row) < MAX_ORDER)
                            vec_reg[ld_row] <= in_val;
                        if (in_cmd == pide_pkg::CMD_START) begin
                            n_reg      <= n_act;
                            iter_reg   <= '0;
                            i_reg      <= '0;
                            j_reg      <= '0;
                            acc_reg    <= '0;
                            mac_ph_reg <= 1'b0;
                            state_reg  <= S_MAC;
                        end
                    end
                end
                // phase 0 reads the matrix, phase 1 accumulates
                S_MAC: begin
                    if (!mac_ph_reg) begin
                        mac_ph_reg <= 1'b1;
                    end else begin
                        mac_ph_reg <= 1'b0;
                        if ({1'b0, j_reg} == (NW+1)'(n_reg) - 1'b1) begin
                            z_reg[i_reg] <= sat37(acc_reg + prod_sh);
                            acc_reg <= '0;
                            j_reg   <= '0;
                            if (last_i) begin
                                i_reg     <= '0;
                                lambda_reg <= '0;
                                if (iter_reg != 16'hFFFF) iter_reg <= iter_reg + 1'b1;
                                state_reg <= S_SCAN;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end else begin
                            acc_reg <= acc_reg + prod_sh;
                            j_reg   <= j_reg + 1'b1;
                        end
                    end
                end
                // first element of greatest magnitude
                S_SCAN: begin
                    if (i_reg == '0 || mag37(z_reg[i_reg]) > mag37(lambda_reg))
                        lambda_reg <= z_reg[i_reg];
                    if (last_i) begin
                        i_reg <= '0;
                        state_reg <= S_CHECK;
                        err_reg <= '0;
                        err_big_reg <= 1'b0;
                        mac_ph_reg <= 1'b1;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_DIVGO: state_reg <= S_DIVW;
                S_DIVW: begin
                    if (drsp.done) begin
                        vec_reg[i_reg] <= y_val;
                        if (y_dmag[VW]) err_big_reg <= 1'b1;
                        else if (y_dmag[VW-1:0] > err_reg) err_reg <= y_dmag[VW-1:0];
                        if (last_i) begin
                            i_reg <= '0;
                            mac_ph_reg <= 1'b0;
                            state_reg <= S_CHECK;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= S_DIVGO;
                        end
                    end
                end
                // mac_ph_reg high: after scan; low: after divides
                S_CHECK: begin
                    if (mac_ph_reg) begin
                        mac_ph_reg <= 1'b0;
                        if (lambda_reg == '0) begin
                            status_reg <= pide_pkg::ST_ZERO;
                            state_reg  <= S_EMIT;
                        end else begin
                            state_reg <= S_DIVGO;
                        end
                    end else if (!err_big_reg && err_reg < {1'b0, tol_reg}) begin
                        status_reg <= pide_pkg::ST_CONVERGED;
                        state_reg  <= S_EMIT;
                    end else if (iter_reg >= limit_reg) begin
                        status_reg <= pide_pkg::ST_LIMIT;
                        state_reg  <= S_EMIT;
                    end else begin
                        acc_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_EMIT: state_reg <= S_DRAIN;
                S_DRAIN: begin
                    if (m_fire) begin
                        if (last_i) begin
                            i_reg <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output word: read live from the stores, held while stalled
    assign m_axis_tvalid = (state_reg == S_DRAIN);
    assign m_axis_tdata  = {1'b0, status_reg, iter_reg, lambda_reg, vec_reg[i_reg]};
    assign m_axis_tuser  = 3'(i_reg);
    assign m_axis_tlast  = last_i;

    // checks
    `PIDE_ASSERT_IMPL(a_ready_idle, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "input taken during output")
    `PIDE_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_fire && m_axis_tlast, state_reg == S_IDLE, "no idle after last word")
    `PIDE_ASSERT_IMPL(a_div_state, aclk, aresetn, drsp.busy, state_reg == S_DIVW, "divider busy outside wait")
endmodule

FILE: tb/power_iteration_checker.sv
// checker for the power iteration block: predicts result words and compares them
module power_iteration_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // row, col, value
    input  logic [1:0]   s_axis_tuser,   // cmd
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [87:0]  m_axis_tdata,   // element, eigenvalue, iterations, status
    input  logic [2:0]   m_axis_tuser,   // index
    input  logic         m_axis_tlast,
    output int           error_count,
    output int           words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Z_MAX = (64'sd1 <<< 36) - 1;
    localparam longint Z_MIN = -(64'sd1 <<< 36);

    typedef struct {
        logic [2:0]                      index;
        logic [pide_pkg::VAL_W-1:0]      element;
        logic [pide_pkg::Z_W-1:0]        eigenvalue;
        logic [pide_pkg::ITER_W-1:0]     iterations;
        logic [1:0]                      status;
        logic                            last;
    } eigen_word_t;

    eigen_word_t expected_words[$];

    // shadow copy of the block state and registers
    logic signed [31:0] mat[8][8];
    logic signed [31:0] vec[8];
    logic [3:0]         order_reg;
    logic [30:0]        tol_reg;
    logic [15:0]        limit_reg;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, exp);
        error_count++;
    endtask

    function automatic longint sat_z(input longint v);
        if (v > Z_MAX) return Z_MAX;
        if (v < Z_MIN) return Z_MIN;
        return v;
    endfunction

    function automatic longint abs_l(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // one start: run passes until a stop test fires, queue one word per element
    function automatic void predict_eigen_run();
        int unsigned n;
        longint prod[8];
        longint acc, lam, y, d, maxerr;
        logic [15:0] iters;
        logic [1:0] st;
        bit done;
        eigen_word_t w;
        n = (order_reg == 0) ? 1 : (order_reg > 8) ? 8 : order_reg;
        iters = 0;
        done = 0;
        st = pide_pkg::ST_CONVERGED;
        lam = 0;
        while (!done) begin
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    acc += (longint'(mat[i][j]) * longint'(vec[j])) >>> 24;
                prod[i] = sat_z(acc);
            end
            if (iters < 16'hFFFF) iters++;
            lam = prod[0];
            for (int i = 1; i < n; i++)
                if (abs_l(prod[i]) > abs_l(lam)) lam = prod[i];
            if (lam == 0) begin
                st = pide_pkg::ST_ZERO;
                done = 1;
            end else begin
                maxerr = 0;
                for (int i = 0; i < n; i++) begin
                    y = (abs_l(prod[i]) <<< 24) / abs_l(lam);
                    if ((prod[i] < 0) != (lam < 0)) y = -y;
                    d = abs_l(y - longint'(vec[i]));
                    if (d > maxerr) maxerr = d;
                    vec[i] = y[31:0];
                end
                if (maxerr < longint'(tol_reg)) begin
                    st = pide_pkg::ST_CONVERGED;
                    done = 1;
                end else if (iters >= limit_reg) begin
                    st = pide_pkg::ST_LIMIT;
                    done = 1;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            w.index = i[2:0];
            w.element = vec[i];
            w.eigenvalue = lam[pide_pkg::Z_W-1:0];
            w.iterations = iters;
            w.status = st;
            w.last = (i == n - 1);
            expected_words.push_back(w);
        end
    endfunction

    initial begin
        error_count = 0;
        words_pending = 0;
    end

    always @(posedge aclk) begin
        eigen_word_t e;
        if (!aresetn) begin
            order_reg = 4'd3;
            tol_reg = 31'd839;
            limit_reg = 16'd1000;
            foreach (mat[i, j]) mat[i][j] = '0;
            foreach (vec[i]) vec[i] = '0;
            expected_words.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    pide_pkg::REG_ORDER: order_reg = cfg_data[3:0];
                    pide_pkg::REG_TOL:   tol_reg = cfg_data;
                    pide_pkg::REG_LIMIT: limit_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            // input words
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    pide_pkg::CMD_MATRIX:
                        mat[s_axis_tdata[2:0]][s_axis_tdata[5:3]] = s_axis_tdata[37:6];
                    pide_pkg::CMD_VECTOR: vec[s_axis_tdata[2:0]] = s_axis_tdata[37:6];
                    pide_pkg::CMD_START:  predict_eigen_run();
                    default: ;
                endcase
            end
            // result words
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", m_axis_tuser, 0);
                end else begin
                    e = expected_words.pop_front();
                    if (m_axis_tuser != e.index)
                        report_mismatch("index", m_axis_tuser, e.index);
                    if (m_axis_tdata[31:0] != e.element)
                        report_mismatch("element", m_axis_tdata[31:0], e.element);
                    if (m_axis_tdata[68:32] != e.eigenvalue)
                        report_mismatch("eigenvalue", m_axis_tdata[68:32], e.eigenvalue);
                    if (m_axis_tdata[84:69] != e.iterations)
                        report_mismatch("iterations", m_axis_tdata[84:69], e.iterations);
                    if (m_axis_tdata[86:85] != e.status)
                        report_mismatch("status", m_axis_tdata[86:85], e.status);
                    if (m_axis_tlast != e.last)
                        report_mismatch("last", m_axis_tlast, e.last);
                end
            end
        end
        words_pending = expected_words.size();
    end
endmodule

FILE: tb/tb.sv
// testbench top for the power iteration block: stimulus, stalls and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [31:0] ONE = 32'h0100_0000;
    localparam logic [31:0] MINUS_TWO = 32'hFE00_0000;
    localparam int WATCHDOG_LIMIT = 200000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // row, col, value
    logic [1:0]  s_axis_tuser = '0;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [87:0] m_axis_tdata;        // element, eigenvalue, iterations, status
    logic [2:0]  m_axis_tuser;        // index
    logic        m_axis_tlast;

    int  error_count;
    int  words_pending;
    bit  idling_on = 1;
    bit  hold_request = 0;
    int  idle_cycles = 0;
    int  items_sent = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    power_iteration_dominant_eigen u_top (.*);

    power_iteration_checker u_chk (.*);

    // receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 0;
                m_axis_tready <= 0;
                repeat (3000) @(posedge aclk);
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 5);
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [2:0] row,
                             input logic [2:0] col, input logic [31:0] value);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {2'b00, value, col, row};
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // drain all expected words, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 0;
        do @(negedge aclk); while (words_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic set_config(input int order, input logic [30:0] tol, input int limit);
        write_reg(pide_pkg::REG_ORDER, 31'(order));
        write_reg(pide_pkg::REG_TOL, tol);
        write_reg(pide_pkg::REG_LIMIT, 31'(limit));
    endtask

    task automatic load_vector(input int n, input logic [31:0] v);
        for (int i = 0; i < n; i++) send_word(pide_pkg::CMD_VECTOR, 3'(i), 3'd0, v);
    endtask

    // diagonal over the first n rows and columns, zero elsewhere in that block
    task automatic load_diag(input int n, input logic [31:0] d);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_word(pide_pkg::CMD_MATRIX, 3'(r), 3'(c), (r == c) ? d : 32'd0);
    endtask

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // fill every entry so no start ever reads an unwritten one
        load_diag(8, MINUS_TWO);
        for (int i = 0; i < 8; i++)
            send_word(pide_pkg::CMD_VECTOR, 3'(i), 3'd0, $urandom());

        // reset settings, 3x3 with well separated eigenvalues
        load_diag(3, ONE);
        send_word(pide_pkg::CMD_MATRIX, 3'd0, 3'd0, 32'h0200_0000);
        send_word(pide_pkg::CMD_MATRIX, 3'd2, 3'd2, 32'hFF80_0000);
        send_word(pide_pkg::CMD_MATRIX, 3'd0, 3'd1, 32'h0010_0000);
        load_vector(3, ONE);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        send_word(CMD_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
        wait_idle();

        // field extremes, saturated products, single pass
        set_config(2, 31'd0, 1);
        send_word(pide_pkg::CMD_MATRIX, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_word(pide_pkg::CMD_MATRIX, 3'd0, 3'd1, 32'h8000_0000);
        send_word(pide_pkg::CMD_MATRIX, 3'd1, 3'd0, 32'h8000_0000);
        send_word(pide_pkg::CMD_MATRIX, 3'd1, 3'd1, 32'h7FFF_FFFF);
        send_word(pide_pkg::CMD_VECTOR, 3'd0, 3'd0, 32'h8000_0000);
        send_word(pide_pkg::CMD_VECTOR, 3'd1, 3'd0, 32'h7FFF_FFFF);
        send_word(pide_pkg::CMD_START, 3'd7, 3'd7, 32'hFFFF_FFFF);
        wait_idle();

        // zero lambda from a zero vector, order zero acts as one
        set_config(0, 31'd839, 0);
        send_word(pide_pkg::CMD_VECTOR, 3'd0, 3'd0, 32'd0);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        wait_idle();

        // oversized order, widest tolerance, longest limit, negative lambda
        set_config(15, 31'h7FFF_FFFF, 65535);
        load_diag(3, MINUS_TWO);
        load_vector(8, ONE);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        wait_idle();
        set_config(8, 31'd839, 65535);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        wait_idle();

        // zero tolerance runs to the limit
        set_config(4, 31'd0, 3);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        wait_idle();

        // receiver holds off while starts keep coming
        idling_on = 0;
        set_config(8, 31'd839, 1);
        hold_request = 1;
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        send_word(pide_pkg::CMD_START, 3'd0, 3'd0, 32'd0);
        wait_idle();
        idling_on = 1;

        // random load and start sequences, last stretch without stalls
        while (items_sent < 130) begin
            if (items_sent > 118) idling_on = 0;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            set_config(n, ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                                      : 31'($urandom_range(0, 100000)),
                       $urandom_range(1, 6));
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 9))
                    0: send_word(CMD_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
                    1, 2, 3: send_word(pide_pkg::CMD_VECTOR, 3'($urandom()), 3'($urandom()),
                                       ($urandom_range(0, 1)) ? $urandom()
                                                              : $urandom_range(0, 32'h0200_0000));
                    default: send_word(pide_pkg::CMD_MATRIX, 3'($urandom()), 3'($urandom()),
                                       ($urandom_range(0, 1)) ? $urandom()
                                                              : $urandom_range(0, 32'h0400_0000));
                endcase
            end
            send_word(pide_pkg::CMD_START, 3'($urandom()), 3'($urandom()), $urandom());
            wait_idle();
        end

        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
